@@ hw/rtl/mpk_pkg.sv @@
`default_nettype none

package mpk_pkg;

  // Result kinds.
  localparam logic [3:0] KIND_NIL     = 4'd0;
  localparam logic [3:0] KIND_BOOL    = 4'd1;
  localparam logic [3:0] KIND_INT     = 4'd2;
  localparam logic [3:0] KIND_F32     = 4'd3;
  localparam logic [3:0] KIND_F64     = 4'd4;
  localparam logic [3:0] KIND_STR     = 4'd5;
  localparam logic [3:0] KIND_BIN     = 4'd6;
  localparam logic [3:0] KIND_ARRAY   = 4'd7;
  localparam logic [3:0] KIND_MAP     = 4'd8;
  localparam logic [3:0] KIND_EXT     = 4'd9;
  localparam logic [3:0] KIND_PAYLOAD = 4'd10;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_TAG   = 2'd1;
  localparam logic [1:0] ERR_RANGE     = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Parser phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_FIELD   = 2'd1;
  localparam logic [1:0] PH_EXTTYPE = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  held_tag;
    logic [3:0]  field_left;
    logic [63:0] acc;
    logic [31:0] payload_left;
  } state_t;

  typedef struct packed {
    logic [3:0]        kind;
    logic [63:0]       value;
    logic [31:0]       size;
    logic signed [7:0] ext_kind;
    logic [1:0]        error;
    logic              last;
  } result_t;

  // Object kind selected by a tag byte.
  function automatic logic [3:0] kind_of(input logic [7:0] t);
    logic [3:0] k;
    if (t <= 8'h7F || t >= 8'hE0) k = KIND_INT;
    else if (t <= 8'h8F) k = KIND_MAP;
    else if (t <= 8'h9F) k = KIND_ARRAY;
    else if (t <= 8'hBF) k = KIND_STR;
    else if (t == 8'hC0) k = KIND_NIL;
    else if (t == 8'hC2 || t == 8'hC3) k = KIND_BOOL;
    else if (t >= 8'hC4 && t <= 8'hC6) k = KIND_BIN;
    else if (t >= 8'hC7 && t <= 8'hC9) k = KIND_EXT;
    else if (t == 8'hCA) k = KIND_F32;
    else if (t == 8'hCB) k = KIND_F64;
    else if (t >= 8'hCC && t <= 8'hD3) k = KIND_INT;
    else if (t >= 8'hD4 && t <= 8'hD8) k = KIND_EXT;
    else if (t >= 8'hD9 && t <= 8'hDB) k = KIND_STR;
    else if (t == 8'hDC || t == 8'hDD) k = KIND_ARRAY;
    else k = KIND_MAP;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/msgpack_object_decoder_core.sv @@
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o  data_byte_i, buffer_end_i
// out      source     out_valid_o / out_stall_i kind_o, value_o, size_o,
//                                              ext_kind_o, error_o, last_o
//
// One encoded byte is taken in every clock cycle unless the input stalls; the
// parser state registers close the only loop, so the sustained rate is one
// byte per cycle. Each result is registered in the cycle after its byte.
// Reset puts the parser in the idle phase awaiting a tag and empties the output.
// The input stalls only while a result sits in the output register and the
// downstream side is stalling it.

module msgpack_object_decoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              buffer_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        kind_o,
  output logic [63:0]       value_o,
  output logic [31:0]       size_o,
  output logic signed [7:0] ext_kind_o,
  output logic [1:0]        error_o,
  output logic              last_o
);
  import mpk_pkg::*;

  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    res_valid;
  logic    out_valid_q, out_valid_d;
  logic    in_accept;

  // A new request may enter whenever the output register is empty or is being
  // drained in this very cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  mpk_step u_step (
    .cur_i        (state_q),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .nxt_o        (state_d),
    .res_valid_o  (res_valid),
    .res_o        (res_d)
  );

  // A byte that yields no result still drains a result that is being taken.
  assign out_valid_d = in_accept ? res_valid : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  // The result payload carries no reset; only the valid flag does.
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign value_o     = res_q.value;
  assign size_o      = res_q.size;
  assign ext_kind_o  = res_q.ext_kind;
  assign error_o     = res_q.error;
  assign last_o      = res_q.last;

`ifndef SYNTHESIS
  a_idle_no_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> state_q.field_left == 4'd0)
    else $error("idle phase with field bytes outstanding");

  a_field_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_FIELD |-> state_q.field_left != 4'd0)
    else $error("field phase with no bytes left");

  a_payload_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_PAYLOAD |-> state_q.payload_left != 32'd0)
    else $error("payload phase with nothing left");

  a_end_goes_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && buffer_end_i) |=> state_q.phase == PH_IDLE)
    else $error("buffer end left an object open");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.error != ERR_NONE) |-> res_q.last)
    else $error("error result not marked last");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mpk_step.sv @@
`default_nettype none

// Next-state and result logic for one encoded byte.
module mpk_step (
  input  mpk_pkg::state_t  cur_i,
  input  logic [7:0]       data_byte_i,
  input  logic             buffer_end_i,
  output mpk_pkg::state_t  nxt_o,
  output logic             res_valid_o,
  output mpk_pkg::result_t res_o
);
  import mpk_pkg::*;

  logic [7:0]  b;
  logic [7:0]  ht;
  logic [3:0]  hk;
  logic [63:0] acc_sh;
  logic [3:0]  field_dec;
  logic [31:0] pl_dec;

  assign b         = data_byte_i;
  assign ht        = cur_i.held_tag;
  assign hk        = kind_of(cur_i.held_tag);
  assign acc_sh    = {cur_i.acc[55:0], b};
  assign field_dec = (cur_i.field_left != 4'd0) ? cur_i.field_left - 4'd1 : 4'd0;
  assign pl_dec    = (cur_i.payload_left != 32'd0) ? cur_i.payload_left - 32'd1 : 32'd0;

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;

    unique case (cur_i.phase)
      PH_IDLE: begin
        nxt_o.held_tag = b;
        nxt_o.acc      = '0;
        if (b <= 8'h7F || b >= 8'hE0) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_INT;
          res_o.value = {{56{b[7]}}, b};
        end else if (b <= 8'h8F) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_MAP;
          res_o.size  = {28'd0, b[3:0]};
        end else if (b <= 8'h9F) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ARRAY;
          res_o.size  = {28'd0, b[3:0]};
        end else if (b <= 8'hBF) begin
          res_valid_o          = 1'b1;
          res_o.kind           = KIND_STR;
          res_o.size           = {27'd0, b[4:0]};
          res_o.last           = (b[4:0] == 5'd0);
          nxt_o.payload_left   = {27'd0, b[4:0]};
          nxt_o.phase          = (b[4:0] != 5'd0) ? PH_PAYLOAD : PH_IDLE;
        end else if (b == 8'hC0) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_NIL;
        end else if (b == 8'hC1) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_NIL;
          res_o.error = ERR_BAD_TAG;
        end else if (b == 8'hC2 || b == 8'hC3) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BOOL;
          res_o.value = {63'd0, b[0]};
        end else if (b <= 8'hC6) begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd1 << 2'(b - 8'hC4);
        end else if (b <= 8'hC9) begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd1 << 2'(b - 8'hC7);
        end else if (b == 8'hCA) begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd4;
        end else if (b == 8'hCB) begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd8;
        end else if (b <= 8'hD3) begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd1 << b[1:0];
        end else if (b <= 8'hD8) begin
          // Fixed-length extension: size is known, so the type byte follows with no length field.
          nxt_o.phase        = PH_EXTTYPE;
          nxt_o.payload_left = 32'd1 << 3'(b - 8'hD4);
        end else if (b <= 8'hDB) begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd1 << 2'(b - 8'hD9);
        end else begin
          nxt_o.phase      = PH_FIELD;
          nxt_o.field_left = 4'd2 << b[0];
        end
      end

      PH_FIELD: begin
        nxt_o.acc        = acc_sh;
        nxt_o.field_left = field_dec;
        if (field_dec == 4'd0) begin
          nxt_o.phase = PH_IDLE;
          if (hk == KIND_F32) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_F32;
            res_o.value = {32'd0, acc_sh[31:0]};
          end else if (hk == KIND_F64) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_F64;
            res_o.value = acc_sh;
          end else if (hk == KIND_INT) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_INT;
            if (ht >= 8'hD0) begin
              unique case (ht[1:0])
                2'd0: res_o.value = {{56{acc_sh[7]}}, acc_sh[7:0]};
                2'd1: res_o.value = {{48{acc_sh[15]}}, acc_sh[15:0]};
                2'd2: res_o.value = {{32{acc_sh[31]}}, acc_sh[31:0]};
                2'd3: res_o.value = acc_sh;
              endcase
            end else if (ht == 8'hCF && acc_sh[63]) begin
              res_o.error = ERR_RANGE;
            end else begin
              res_o.value = acc_sh;
            end
          end else if (hk == KIND_STR || hk == KIND_BIN) begin
            res_valid_o        = 1'b1;
            res_o.kind         = hk;
            res_o.size         = acc_sh[31:0];
            res_o.last         = (acc_sh[31:0] == 32'd0);
            nxt_o.payload_left = acc_sh[31:0];
            nxt_o.phase        = (acc_sh[31:0] != 32'd0) ? PH_PAYLOAD : PH_IDLE;
          end else if (hk == KIND_EXT) begin
            nxt_o.payload_left = acc_sh[31:0];
            nxt_o.phase        = PH_EXTTYPE;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind  = hk;
            res_o.size  = acc_sh[31:0];
          end
        end
      end

      PH_EXTTYPE: begin
        res_valid_o    = 1'b1;
        res_o.kind     = KIND_EXT;
        res_o.size     = cur_i.payload_left;
        res_o.ext_kind = b;
        res_o.last     = (cur_i.payload_left == 32'd0);
        nxt_o.phase    = (cur_i.payload_left != 32'd0) ? PH_PAYLOAD : PH_IDLE;
      end

      PH_PAYLOAD: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.value        = {56'd0, b};
        res_o.last         = (pl_dec == 32'd0);
        nxt_o.payload_left = pl_dec;
        nxt_o.phase        = (pl_dec != 32'd0) ? PH_PAYLOAD : PH_IDLE;
      end
    endcase

    // The buffer ran out with an object still open.
    if (buffer_end_i && nxt_o.phase != PH_IDLE) begin
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.error = ERR_TRUNCATED;
      res_o.last  = 1'b1;
      if (cur_i.phase == PH_PAYLOAD) begin
        res_o.kind  = KIND_PAYLOAD;
        res_o.value = {56'd0, b};
      end else begin
        res_o.kind = kind_of(nxt_o.held_tag);
      end
      nxt_o.phase        = PH_IDLE;
      nxt_o.field_left   = 4'd0;
      nxt_o.payload_left = 32'd0;
    end
  end

endmodule

`default_nettype wire
